@@ rtl/sha1md_pkg.sv @@
// shared types and constants of the sha-1 message digest core
// no dependencies; imported by every module of the core
`default_nettype none

package sha1md_pkg;

  // kind of a queue entry between intake and compression
  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  // one queue entry: a full big-endian word, or the closing word of a message
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  nbytes;  // message bytes in word, 4 for a full word
    logic [31:0] word;    // closing word already carries the 0x80 marker when nbytes < 4
  } entry_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  localparam logic [2:0] FullBytes = 3'd4;

  // initial chaining value, index 0 is H0
  localparam logic [4:0][31:0] HInit = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] PadMarker = 32'h8000_0000;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [2:0] LastWord  = 3'd4;

endpackage

`default_nettype wire

@@ rtl/sha1md_front.sv @@
// intake stage: gathers message bytes into big-endian words and closes messages
// depends on sha1md_pkg
`default_nettype none

module sha1md_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] message_byte
  input  wire logic                  s_axis_tuser,   // [0] has_byte
  input  wire logic                  s_axis_tlast,   // end_of_message
  input  wire logic                  full_i,
  output logic                       push_o,
  output sha1md_pkg::entry_t         entry_o
);
  import sha1md_pkg::*;

  logic [23:0] acc_q, acc_d, acc_new;
  logic [1:0]  cnt_q, cnt_d, cnt_new;
  logic        accept;

  assign s_axis_tready = ~full_i;
  assign accept        = s_axis_tvalid & ~full_i;

  always_comb begin
    acc_new = s_axis_tuser ? {acc_q[15:0], s_axis_tdata} : acc_q;
    cnt_new = s_axis_tuser ? cnt_q + 2'd1 : cnt_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    entry_o.kind   = KIND_END;
    entry_o.nbytes = {1'b0, cnt_new};
    unique case (cnt_new)
      2'd0:    entry_o.word = PadMarker;
      2'd1:    entry_o.word = {acc_new[7:0], 8'h80, 16'h0000};
      2'd2:    entry_o.word = {acc_new[15:0], 8'h80, 8'h00};
      default: entry_o.word = {acc_new[23:0], 8'h80};
    endcase
    if (s_axis_tuser && cnt_q == 2'd3) begin
      // this byte completes a word
      entry_o.word   = {acc_q, s_axis_tdata};
      entry_o.nbytes = FullBytes;
      entry_o.kind   = s_axis_tlast ? KIND_END : KIND_WORD;
      push_o         = accept;
      cnt_d          = 2'd0;
      acc_d          = acc_new;
    end else begin
      push_o = accept & s_axis_tlast;
      acc_d  = acc_new;
      cnt_d  = s_axis_tlast ? 2'd0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha1md_fifo.sv @@
// small register queue between intake and compression
// depends on sha1md_pkg
`default_nettype none

module sha1md_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  sha1md_pkg::entry_t      entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output sha1md_pkg::entry_t      entry_o
);
  import sha1md_pkg::*;

  entry_t              mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]     count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (FifoAw + 1)'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha1md_back.sv @@
// compression stage: block assembly, padding, 80-round loop and digest output
// depends on sha1md_pkg
`default_nettype none

module sha1md_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  sha1md_pkg::entry_t      entry_i,
  output logic                    pop_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [39:0]             m_axis_tdata,   // [31:0] digest_word, [34:32] word_number
  output logic                    m_axis_tlast    // last_word
);
  import sha1md_pkg::*;

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [4:0][31:0]  h_q;
  logic [63:0]       len_q;
  logic [3:0]        widx_q;
  logic [6:0]        rnd_q;
  logic [2:0]        oidx_q;
  logic              pad_q, mark_q, room_q, final_q;

  logic [31:0]       w_q [16];
  logic [31:0]       a_q, b_q, c_q, d_q, e_q;
  logic              out_valid_q;
  logic [31:0]       out_word_q;
  logic [2:0]        out_num_q;
  logic              out_last_q;

  logic [31:0]       shift_word, pad_word, f, k, t, sched, mix;
  logic              shift_en, out_load;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_num_q, out_word_q};
  assign m_axis_tlast  = out_last_q;

  assign pop_o    = (state_q == StLoad) & valid_i;
  assign out_load = (state_q == StOut) & (~out_valid_q | m_axis_tready);

  // padding words: marker if still owed, then zeros, length in the last two slots
  always_comb begin
    pad_word = '0;
    if (mark_q) begin
      pad_word = PadMarker;
    end else if (room_q && widx_q == 4'd14) begin
      pad_word = len_q[63:32];
    end else if (room_q && widx_q == 4'd15) begin
      pad_word = len_q[31:0];
    end
  end

  // round function
  always_comb begin
    priority if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    mix   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    sched = {mix[30:0], mix[31]};
  end

  always_comb begin
    shift_en   = 1'b0;
    shift_word = pad_word;
    unique case (state_q)
      StLoad: begin
        shift_en   = valid_i;
        shift_word = entry_i.word;
      end
      StPad: begin
        shift_en = 1'b1;
      end
      StRound: begin
        shift_en   = 1'b1;
        shift_word = sched;
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (valid_i) begin
          if (widx_q == 4'd15) begin
            state_d = StRound;
          end else if (entry_i.kind == KIND_END) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (widx_q == 4'd15) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (rnd_q == LastRound) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        priority if (final_q) begin
          state_d = StOut;
        end else if (pad_q) begin
          state_d = StPad;
        end else begin
          state_d = StLoad;
        end
      end
      StOut: begin
        if (out_load && oidx_q == LastWord) begin
          state_d = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      h_q         <= HInit;
      len_q       <= '0;
      widx_q      <= '0;
      rnd_q       <= '0;
      oidx_q      <= '0;
      pad_q       <= 1'b0;
      mark_q      <= 1'b0;
      room_q      <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (valid_i) begin
            widx_q <= widx_q + 4'd1;
            len_q  <= len_q + {58'd0, entry_i.nbytes, 3'd0};
            if (entry_i.kind == KIND_END) begin
              pad_q <= 1'b1;
              if (entry_i.nbytes == FullBytes) begin
                mark_q <= 1'b1;
              end else begin
                room_q <= (widx_q <= 4'd13);
              end
            end
          end
        end
        StPad: begin
          widx_q <= widx_q + 4'd1;
          if (mark_q) begin
            mark_q <= 1'b0;
            room_q <= (widx_q <= 4'd13);
          end else if (room_q && widx_q == 4'd15) begin
            final_q <= 1'b1;
          end
        end
        StRound: begin
          rnd_q <= (rnd_q == LastRound) ? 7'd0 : rnd_q + 7'd1;
        end
        StAdd: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q;
          room_q <= 1'b1;
        end
        StOut: begin
          if (out_load) begin
            if (oidx_q == LastWord) begin
              // digest captured, back to a fresh message
              oidx_q  <= '0;
              h_q     <= HInit;
              len_q   <= '0;
              pad_q   <= 1'b0;
              mark_q  <= 1'b0;
              room_q  <= 1'b0;
              final_q <= 1'b0;
            end else begin
              oidx_q <= oidx_q + 3'd1;
            end
          end
        end
        default: begin
          rnd_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= shift_word;
    end
    if (state_q == StRound) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else if (state_q == StLoad || state_q == StPad) begin
      // chaining value is stable here, so preload the round registers
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end
    if (out_load) begin
      out_word_q <= h_q[oidx_q];
      out_num_q  <= oidx_q;
      out_last_q <= (oidx_q == LastWord);
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha1_message_digest_core.sv @@
// SHA-1 core: one message byte per input transfer, 160-bit digest out as five
// 32-bit words. Bytes are gathered into words at one byte a cycle while the queue
// has room and pass through a four-word queue to the compression engine, which
// loads a 64-byte block as 16 words, runs the 80 rounds at one round a cycle and
// then folds the result into the chaining value. Byte intake runs on while the
// rounds run until the queue fills; during the load the engine waits on intake
// for twelve of the sixteen words. A transfer with tlast closes the message:
// padding and the length fill out the current block, plus one further block when
// the length does not fit, and the digest words follow, H0 first, with tlast on
// H4. The core then starts over from the initial chaining value. tuser low marks
// a transfer that carries no byte.
// depends on sha1md_pkg, sha1md_front, sha1md_fifo, sha1md_back
`default_nettype none

module sha1_message_digest_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] message_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_number
  output logic             m_axis_tlast    // last_word
);
  import sha1md_pkg::*;

  entry_t push_entry, pop_entry;
  logic   push, full, pop, q_valid;

  sha1md_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  sha1md_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  sha1md_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ test/sha1_message_digest_core_tb.sv @@
// testbench for the sha-1 message digest core: byte stream in, five digest words out
// a scoreboard class recomputes each digest from the accepted byte transfers
// depends on rtl/sha1_message_digest_core.sv and rtl/sha1md_pkg.sv
`timescale 1ns / 1ps

module sha1_message_digest_core_tb;

  localparam int unsigned MaxGap      = 14;
  localparam int unsigned ItemTarget  = 430;
  localparam int unsigned MinMessages = 12;
  localparam int unsigned DrainCycles = 300;

  localparam bit [31:0] IvH0 = 32'h67452301;
  localparam bit [31:0] IvH1 = 32'hefcdab89;
  localparam bit [31:0] IvH2 = 32'h98badcfe;
  localparam bit [31:0] IvH3 = 32'h10325476;
  localparam bit [31:0] IvH4 = 32'hc3d2e1f0;

  localparam bit [31:0] RoundK0 = 32'h5a827999;
  localparam bit [31:0] RoundK1 = 32'h6ed9eba1;
  localparam bit [31:0] RoundK2 = 32'h8f1bbcdc;
  localparam bit [31:0] RoundK3 = 32'hca62c1d6;

  localparam bit [7:0] PadByte = 8'h80;

  typedef struct {
    bit [31:0] digest;
    bit [2:0]  index;
    bit        last;
  } digest_word_t;

  class digest_scoreboard;
    bit [31:0]    chain[5];
    bit [7:0]     block_bytes[64];
    int unsigned  fill;
    bit [63:0]    bit_count;
    digest_word_t digest_words_due[$];
    int unsigned  errors;
    int unsigned  words_checked;

    function void restart_chain();
      chain[0] = IvH0;
      chain[1] = IvH1;
      chain[2] = IvH2;
      chain[3] = IvH3;
      chain[4] = IvH4;
      fill = 0;
      bit_count = '0;
    endfunction

    function new();
      errors = 0;
      words_checked = 0;
      restart_chain();
    endfunction

    // 80 rounds over the buffered block, added into the chaining words
    function void fold_block();
      bit [31:0] w[16];
      bit [31:0] a, b, c, d, e, f, k, t;
      int unsigned s;
      for (int i = 0; i < 16; i++) begin
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        s = r & 15;
        if (r >= 16) begin
          t = w[(s + 13) & 15] ^ w[(s + 8) & 15] ^ w[(s + 2) & 15] ^ w[s];
          w[s] = {t[30:0], t[31]};
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = RoundK0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = RoundK1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = RoundK2;
        end else begin
          f = b ^ c ^ d;
          k = RoundK3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[s];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void note_transfer(bit [7:0] data, bit has_byte, bit end_of_msg);
      digest_word_t dw;
      if (has_byte) begin
        block_bytes[fill] = data;
        fill++;
        bit_count += 64'd8;
        if (fill == 64) begin
          fold_block();
          fill = 0;
        end
      end
      if (!end_of_msg) return;
      block_bytes[fill] = PadByte;
      for (int i = fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // no room for the length: it goes into an extra block
      if (fill >= 56) begin
        fold_block();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_bytes[63-i] = bit_count[8*i +: 8];
      fold_block();
      for (int i = 0; i < 5; i++) begin
        dw.digest = chain[i];
        dw.index  = i[2:0];
        dw.last   = (i == 4);
        digest_words_due.push_back(dw);
      end
      restart_chain();
    endfunction

    function void check_word(bit [39:0] data, bit last);
      digest_word_t dw;
      if (digest_words_due.size() == 0) begin
        $error("digest word %h arrived with no digest pending", data[31:0]);
        errors++;
        return;
      end
      dw = digest_words_due.pop_front();
      words_checked++;
      if (data[31:0] !== dw.digest) begin
        $error("digest_word: expected %h, got %h", dw.digest, data[31:0]);
        errors++;
      end
      if (data[34:32] !== dw.index) begin
        $error("word_number: expected %0d, got %0d", dw.index, data[34:32]);
        errors++;
      end
      if (last !== dw.last) begin
        $error("last_word: expected %0b, got %0b", dw.last, last);
        errors++;
      end
      if (data[39:35] !== 5'd0) begin
        $error("tdata fill bits: expected %h, got %h", 5'd0, data[39:35]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return digest_words_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] message_byte
  logic        s_axis_tuser = 1'b0; // [0] has_byte
  logic        s_axis_tlast = 1'b0; // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] digest_word, [34:32] word_number
  logic        m_axis_tlast;        // last_word

  digest_scoreboard sb = new();

  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned items_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned longest_message = 0;

  sha1_message_digest_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(bit [7:0] data, bit has_byte, bit end_of_msg);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tuser  = has_byte;
    s_axis_tlast  = end_of_msg;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_transfer(data, has_byte, end_of_msg);
    items_sent++;
    if (end_of_msg) messages_sent++;
    @(negedge clk_i);
  endtask

  // short messages in seven of sixteen picks, the rest near the block and padding boundaries
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 15))
      0: return 55;
      1: return 56;
      2: return 57;
      3: return 63;
      4: return 64;
      5: return 65;
      6: return 119;
      7: return 120;
      8: return 128;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  task automatic send_message(int unsigned len);
    bit tail_on_byte;
    tail_on_byte = (len > 0) && $urandom_range(0, 1);
    if (len > longest_message) longest_message = len;
    for (int unsigned i = 0; i < len; i++) begin
      // occasional empty transfer with a junk byte inside the message
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, tail_on_byte && (i == len - 1));
    end
    if (!tail_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // output side: random stall before every word, with stall-free stretches
  initial begin
    int unsigned gap;
    int unsigned run_left;
    run_left = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (run_left == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(5, 25);
      end
      run_left--;
      gap = draw_gap(rx_burst);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_word(m_axis_tdata, m_axis_tlast);
      @(negedge clk_i);
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d digest words outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned guard;
    int unsigned len;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty transfer, empty message, "abc", extreme bytes
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h34, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    while (items_sent < ItemTarget || messages_sent < MinMessages) begin
      tx_burst = ($urandom_range(0, 2) == 0);
      len = pick_length();
      // keep the last message from running far past the item budget
      if (items_sent + len > ItemTarget) begin
        len = (items_sent < ItemTarget) ? ItemTarget - items_sent : 0;
      end
      send_message(len);
    end
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d input transfers in %0d messages, longest %0d bytes",
             items_sent, messages_sent, longest_message);
    $display("checked %0d digest words, %0d mismatches", sb.words_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
